FILE: hdl/mexp_pkg.sv
// shared constants and interface types of the modular exponentiation core
// no dependencies; used by mexp_mulmod and modular_exponentiation_core
package mexp_pkg;

  localparam int FIELD_W       = 32;
  localparam int OPERAND_WIDTH = 32;
  localparam int CNT_W         = $clog2(OPERAND_WIDTH);
  localparam int ADDR_W        = 3;

  localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(23);

  // register index decoded from paddr[2]
  localparam logic REG_MODULUS = 1'b0;

  typedef struct packed {
    logic                     start;
    logic [OPERAND_WIDTH-1:0] a;
    logic [OPERAND_WIDTH-1:0] b;
  } mexp_mul_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic [OPERAND_WIDTH-1:0] result;
  } mexp_mul_rsp_t;

endpackage

FILE: hdl/mexp_mulmod.sv
// bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle
// depends on mexp_pkg
module mexp_mulmod (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mexp_pkg::OPERAND_WIDTH-1:0]  modulus,
  input  mexp_pkg::mexp_mul_req_t             req,
  output mexp_pkg::mexp_mul_rsp_t             rsp
);

  localparam int W = mexp_pkg::OPERAND_WIDTH;

  logic [W-1:0]                 acc_r, acc_nxt;
  logic [W-1:0]                 a_r;
  logic [W-1:0]                 b_r;
  logic [mexp_pkg::CNT_W-1:0]   cnt_r;
  logic                         busy_r;
  logic                         done_r;

  logic [W:0] dbl, dbl_red, sum, sum_red, mod_ext;

  // acc = 2*acc mod m, then add a mod m when the scanned bit is set
  always_comb begin
    mod_ext = {1'b0, modulus};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum     = dbl_red + {1'b0, a_r};
    sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    acc_nxt = b_r[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        a_r    <= req.a;
        b_r    <= req.b;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= {b_r[W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == mexp_pkg::CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

FILE: hdl/modular_exponentiation_core.sv
// Modular exponentiation core: out_power_result = in_base_value ^ in_exponent_value mod modulus,
// computed right to left by square-and-multiply on one shared bit-serial modular multiplier.
// An item first reduces the base (one product), then for each exponent bit up to the highest
// set bit runs a multiply when the bit is set and a square unless no higher bit remains. A
// zero exponent finishes after the reduction, and a zero modulus goes straight to the finish
// state. in_ready is high only while no item is at work; one finished result can wait in the
// output register while the next item runs. The modulus register (reset 23) is written
// through the APB port at any address with paddr[2] clear.
// depends on mexp_pkg and mexp_mulmod
module modular_exponentiation_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mexp_pkg::FIELD_W-1:0]      in_base_value,
  input  logic [mexp_pkg::FIELD_W-1:0]      in_exponent_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mexp_pkg::FIELD_W-1:0]      out_power_result,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mexp_pkg::ADDR_W-1:0]       paddr,
  input  logic [mexp_pkg::FIELD_W-1:0]      pwdata,
  output logic [mexp_pkg::FIELD_W-1:0]      prdata,
  output logic                              pready
);

  localparam int W = mexp_pkg::OPERAND_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

  state_t                          state_r;
  logic [mexp_pkg::FIELD_W-1:0]    modulus_r;
  logic [W-1:0]                    acc_r;
  logic [W-1:0]                    base_r;
  logic [W-1:0]                    exp_r;
  logic [W-1:0]                    exp_shift;
  logic                            start_r;
  logic                            out_valid_r;
  logic [mexp_pkg::FIELD_W-1:0]    out_power_result_r;
  logic [W-1:0]                    mod_op;

  mexp_pkg::mexp_mul_req_t         mul_req;
  mexp_pkg::mexp_mul_rsp_t         mul_rsp;

  // ---------------------------------------------------------------------
  // configuration port: zero-wait writes and reads
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mexp_pkg::REG_MODULUS) ? modulus_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mexp_pkg::MODULUS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mexp_pkg::REG_MODULUS) begin
      modulus_r <= pwdata;
    end
  end

  assign mod_op = W'(modulus_r);

  // ---------------------------------------------------------------------
  // operand selection for the shared multiplier
  // ---------------------------------------------------------------------
  always_comb begin
    mul_req.start = start_r;
    unique case (state_r)
      // base mod m as 1 * base: the multiplier scans b without needing b < m
      ST_REDUCE: begin
        mul_req.a = W'(1);
        mul_req.b = base_r;
      end
      ST_MUL: begin
        mul_req.a = acc_r;
        mul_req.b = base_r;
      end
      default: begin
        mul_req.a = base_r;
        mul_req.b = base_r;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (mod_op),
    .req     (mul_req),
    .rsp     (mul_rsp)
  );

  assign exp_shift = exp_r >> 1;

  // ---------------------------------------------------------------------
  // sequencer: reduce, then multiply / square per exponent bit
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      // the finish state reloads the output register itself
      if (out_valid_r && out_ready && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            base_r <= W'(in_base_value);
            exp_r  <= W'(in_exponent_value);
            if (mod_op == '0) begin
              // no reduction defined for a zero modulus: answer zero
              acc_r   <= '0;
              state_r <= ST_FINISH;
            end else begin
              // 1 mod m is zero only for a modulus of one
              acc_r   <= (mod_op == W'(1)) ? '0 : W'(1);
              start_r <= 1'b1;
              state_r <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mul_rsp.done) begin
            base_r <= mul_rsp.result;
            if (exp_r == '0) begin
              state_r <= ST_FINISH;
            end else begin
              start_r <= 1'b1;
              state_r <= exp_r[0] ? ST_MUL : ST_SQR;
            end
          end
        end
        ST_MUL: begin
          if (mul_rsp.done) begin
            acc_r <= mul_rsp.result;
            if (exp_shift == '0) begin
              // top bit used: the last square is not needed
              state_r <= ST_FINISH;
            end else begin
              start_r <= 1'b1;
              state_r <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          if (mul_rsp.done) begin
            base_r <= mul_rsp.result;
            exp_r  <= exp_shift;
            if (exp_shift == '0) begin
              state_r <= ST_FINISH;
            end else begin
              start_r <= 1'b1;
              state_r <= exp_shift[0] ? ST_MUL : ST_SQR;
            end
          end
        end
        ST_FINISH: begin
          // hand the result over once the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r        <= 1'b1;
            out_power_result_r <= mexp_pkg::FIELD_W'(acc_r);
            state_r            <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_power_result_r;

`ifndef NO_ASSERTIONS
  // the multiplier reports completion only while the sequencer waits on it
  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == ST_REDUCE || state_r == ST_MUL || state_r == ST_SQR))
    else $error("multiplier done outside an operation state");

  // a new product is never launched while the previous one is still running
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // a delivered result is always reduced below the modulus, or zero
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_power_result_r < modulus_r || out_power_result_r == '0))
    else $error("result not reduced modulo modulus");

  // a new result only appears out of the finish state
  a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result loaded outside finish state");
`endif

endmodule
